/* design/lkvc_pkg.sv */
// ---------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants of the least-recently-used key-value cache.
// ---------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

   // store geometry
   localparam int unsigned CAPACITY  = 16;
   localparam int unsigned SLOT_W    = $clog2(CAPACITY);
   localparam int unsigned COUNT_W   = 5;
   localparam int unsigned DATA_W    = 32;

   // capacity register reset value, limited to the store size
   localparam logic [COUNT_W-1:0] CAP_RESET = COUNT_W'(CAPACITY);

   // operation codes
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // register index of the capacity register
   localparam logic REG_CAPACITY = 1'b0;

   // value returned by a get that misses
   localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // latch the item and the lookup result
      logic commit;    // update the store and load the result register
   } cmd_type;

endpackage

`default_nettype wire

/* design/lkvc_ctrl.sv */
// ---------------------------------------------------------------------------
// lkvc_ctrl
// Controller: two-step sequence per item and result valid tracking.
// ---------------------------------------------------------------------------
`default_nettype none

module lkvc_ctrl
   import lkvc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  wire logic    rsp_tready,
   output cmd_type      cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // state and result valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // take an item once the result register is free or draining
            req_tready  = !rsp_valid_ff || rsp_tready;
            cmd.capture = req_tvalid && req_tready;
            if (cmd.capture) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result valid: set on commit, cleared when taken
   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

/* design/lkvc_datapath.sv */
// ---------------------------------------------------------------------------
// lkvc_datapath
// Entry store, parallel key match, recency ranks and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module lkvc_datapath
   import lkvc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cmd_type                  cmd,
   input  wire logic                     req_operation,
   input  wire logic signed [DATA_W-1:0] req_key,
   input  wire logic signed [DATA_W-1:0] req_value,
   input  wire logic                     cfg_write,
   input  wire logic [COUNT_W-1:0]       cfg_data,
   output logic [COUNT_W-1:0]            capacity,
   output logic                          rsp_found,
   output logic signed [DATA_W-1:0]      rsp_read_value,
   output logic                          rsp_evicted,
   output logic signed [DATA_W-1:0]      rsp_evicted_key
);

   // entry store
   logic signed [DATA_W-1:0] key_ff   [CAPACITY];
   logic signed [DATA_W-1:0] value_ff [CAPACITY];
   logic [CAPACITY-1:0]      valid_ff, valid_in;
   logic [SLOT_W-1:0]        rank_ff  [CAPACITY];
   logic [SLOT_W-1:0]        rank_in  [CAPACITY];
   logic [COUNT_W-1:0]       occ_ff, occ_in;
   logic [COUNT_W-1:0]       cap_ff, cap_in;

   // captured item and lookup outcome
   logic                     op_ff;
   logic signed [DATA_W-1:0] item_key_ff, item_value_ff;
   logic                     hit_ff, victim_found_ff, free_found_ff;
   logic [SLOT_W-1:0]        hit_idx_ff, victim_idx_ff, free_idx_ff;

   // lookup signals
   logic                     hit, victim_found, free_found, full;
   logic [SLOT_W-1:0]        hit_idx, victim_idx, free_idx;
   logic [COUNT_W-1:0]       occ_last;

   // update signals
   logic                     do_evict, do_insert, do_touch;
   logic [SLOT_W-1:0]        target;
   logic [COUNT_W-1:0]       old_rank;

   // result register
   logic                     found_ff;
   logic signed [DATA_W-1:0] read_value_ff, read_value_in;
   logic                     evicted_ff;
   logic signed [DATA_W-1:0] evicted_key_ff, evicted_key_in;

   // key match, victim search and free slot search, lowest slot wins
   assign full     = occ_ff >= cap_ff;
   assign occ_last = occ_ff - COUNT_W'(1);
   always_comb begin
      hit          = 1'b0;
      hit_idx      = '0;
      victim_found = 1'b0;
      victim_idx   = '0;
      free_found   = 1'b0;
      free_idx     = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (valid_ff[i] && (key_ff[i] == req_key)) begin
            hit     = 1'b1;
            hit_idx = SLOT_W'(i);
         end
         if (valid_ff[i] && full && ({1'b0, rank_ff[i]} == occ_last)) begin
            victim_found = 1'b1;
            victim_idx   = SLOT_W'(i);
         end
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   // capture the item with its lookup outcome
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff           <= req_operation;
         item_key_ff     <= req_key;
         item_value_ff   <= req_value;
         hit_ff          <= hit;
         hit_idx_ff      <= hit_idx;
         victim_found_ff <= victim_found;
         victim_idx_ff   <= victim_idx;
         free_found_ff   <= free_found;
         free_idx_ff     <= free_idx;
      end
   end

   // choose the slot that becomes most recent
   assign do_evict  = !hit_ff && (op_ff == OP_PUT) && victim_found_ff;
   assign do_insert = !hit_ff && (op_ff == OP_PUT) && !victim_found_ff && free_found_ff;
   assign do_touch  = hit_ff || do_evict || do_insert;
   always_comb begin
      if (hit_ff) begin
         target   = hit_idx_ff;
         old_rank = {1'b0, rank_ff[hit_idx_ff]};
      end else if (do_evict) begin
         target   = victim_idx_ff;
         old_rank = {1'b0, rank_ff[victim_idx_ff]};
      end else begin
         target   = free_idx_ff;
         old_rank = occ_ff;
      end
   end

   // rank ageing and valid marks
   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      for (int i = 0; i < CAPACITY; i++) begin
         rank_in[i] = rank_ff[i];
         if (cmd.commit && do_touch) begin
            if (SLOT_W'(i) == target) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && ({1'b0, rank_ff[i]} < old_rank)) begin
               rank_in[i] = rank_ff[i] + SLOT_W'(1);
            end
         end
      end
      if (cmd.commit && do_insert) begin
         valid_in[free_idx_ff] = 1'b1;
         occ_in                = occ_ff + COUNT_W'(1);
      end
   end

   // capacity register: zero reads as one, saturates at the store size,
   // taken only while the store is empty
   always_comb begin
      cap_in = cap_ff;
      if (cfg_write && (occ_ff == '0)) begin
         if (cfg_data == '0) begin
            cap_in = COUNT_W'(1);
         end else if (cfg_data > COUNT_W'(CAPACITY)) begin
            cap_in = COUNT_W'(CAPACITY);
         end else begin
            cap_in = cfg_data;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         cap_ff   <= CAP_RESET;
         for (int i = 0; i < CAPACITY; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
         cap_ff   <= cap_in;
         for (int i = 0; i < CAPACITY; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   // key and value write-back
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if ((hit_ff && (op_ff == OP_PUT)) || do_evict || do_insert) begin
            value_ff[target] <= item_value_ff;
         end
         if (do_evict || do_insert) begin
            key_ff[target] <= item_key_ff;
         end
      end
   end

   // result fields
   always_comb begin
      if (hit_ff && (op_ff == OP_GET)) begin
         read_value_in = value_ff[hit_idx_ff];
      end else if (op_ff == OP_GET) begin
         read_value_in = MISS_VALUE;
      end else begin
         read_value_in = '0;
      end
      evicted_key_in = do_evict ? key_ff[victim_idx_ff] : '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         found_ff       <= hit_ff;
         read_value_ff  <= read_value_in;
         evicted_ff     <= do_evict;
         evicted_key_ff <= evicted_key_in;
      end
   end

   assign capacity        = cap_ff;
   assign rsp_found       = found_ff;
   assign rsp_read_value  = read_value_ff;
   assign rsp_evicted     = evicted_ff;
   assign rsp_evicted_key = evicted_key_ff;

endmodule

`default_nettype wire

/* design/lru_key_value_cache_unit.sv */
// ---------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key-value cache with least-recently-used replacement.
// ---------------------------------------------------------------------------
// Each item is a get or a put of a signed 32-bit key and value and passes
// through a lookup step and an update step: the lookup compares the key
// against all sixteen entries in parallel and captures the item with its
// outcome; the update ages the recency ranks, writes the entry back and
// loads the result register, which then offers the result. A new item is
// taken only once the previous result has been taken or is taken in the
// same cycle, and never during an update; a stalled receiver stalls the input.
// The capacity register at byte address 0 takes data bits [4:0] and is written
// only while the cache is empty; zero reads back as one, 17 to 31 saturate.
`default_nettype none

module lru_key_value_cache_unit
   import lkvc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // lookup_key [31:0], store_value [63:32]
   input  wire logic [0:0]  req_tuser,   // operation [0]
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // read_value [31:0], evicted_key [63:32]
   output logic [1:0]       rsp_tuser,   // found [0], evicted [1]
   // configuration port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   cmd_type                  cmd;
   logic                     cfg_write;
   logic [COUNT_W-1:0]       capacity;
   logic                     found, evicted;
   logic signed [DATA_W-1:0] read_value, evicted_key;

   // register decode
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_CAPACITY);
   assign csr_prdata = (csr_paddr[2] == REG_CAPACITY)
                       ? {{(32-COUNT_W){1'b0}}, capacity} : '0;

   lkvc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   lkvc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_operation   (req_tuser[0]),
      .req_key         (req_tdata[31:0]),
      .req_value       (req_tdata[63:32]),
      .cfg_write       (cfg_write),
      .cfg_data        (csr_pwdata[COUNT_W-1:0]),
      .capacity        (capacity),
      .rsp_found       (found),
      .rsp_read_value  (read_value),
      .rsp_evicted     (evicted),
      .rsp_evicted_key (evicted_key)
   );

   // pack the result
   assign rsp_tdata = {evicted_key, read_value};
   assign rsp_tuser = {evicted, found};

endmodule

`default_nettype wire
